/* rtl/plm_pkg.sv */
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types, widths, register codes and reset values of the peer
// liveness monitor.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int PEER_COUNT_DEF             = 4;
    localparam int LIVENESS_PAYLOAD_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH                = 2;

    localparam int ADDR_W     = 48;
    localparam int TIMER_W    = 16;
    localparam int TYPE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int SELF_W     = 2;
    localparam int HB_W       = 17;
    localparam int IDX_W      = 3;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    localparam logic [IDX_W-1:0] UNKNOWN_INDEX = 3'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDR_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_RELOAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_INDEX       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVENESS_TYPE    = 3'd7;

    localparam logic [TIMER_W-1:0] TIMEOUT_RELOAD_RST   = 16'd1000;
    localparam logic [TIMER_W-1:0] HEARTBEAT_PERIOD_RST = 16'd500;
    localparam logic [SELF_W-1:0]  SELF_INDEX_RST       = 2'd0;
    localparam logic [TYPE_W-1:0]  LIVENESS_TYPE_RST    = 8'd6;

    typedef struct packed {
        logic                is_tick;
        logic [TIMER_W-1:0]  elapsed;
        logic [IDX_W-1:0]    sender_index;
        logic                frame_ok;
    } t_op;

    typedef struct packed {
        logic                frame_accepted;
        logic [IDX_W-1:0]    sender_index;
        logic                send_heartbeat;
        logic [MASK_W-1:0]   alive_mask;
    } t_res;

endpackage

/* rtl/plm_front.sv */
// ----------------------------------------------------------------------------
// plm_front
// Accepts input transfers, matches the sender address against the peer
// table and classifies each item into an operation for the queue.
// ----------------------------------------------------------------------------
module plm_front
    import plm_pkg::*;
#(
    parameter int PEER_COUNT             = PEER_COUNT_DEF,
    parameter int LIVENESS_PAYLOAD_BYTES = LIVENESS_PAYLOAD_BYTES_DEF
) (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_user,
    input  logic [ADDR_W-1:0]    i_peer_addr [PEER_COUNT],
    input  logic [TYPE_W-1:0]    i_liveness_type,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output t_op                  o_op
);

    localparam logic [LEN_W:0] MIN_LEN = (LEN_W+1)'(LIVENESS_PAYLOAD_BYTES + 1);

    logic [TIMER_W-1:0] elapsed;
    logic [ADDR_W-1:0]  sender_addr;
    logic [TYPE_W-1:0]  msg_type;
    logic [LEN_W-1:0]   frame_len;
    logic [IDX_W-1:0]   match_idx;
    logic               is_tick;

    assign elapsed     = i_data[15:0];
    assign sender_addr = i_data[63:16];
    assign msg_type    = i_data[71:64];
    assign frame_len   = i_data[79:72];
    assign is_tick     = (i_user == CMD_TICK);

    // lowest matching index wins
    always_comb begin
        match_idx = UNKNOWN_INDEX;
        for (int i = PEER_COUNT - 1; i >= 0; i--) begin
            if (sender_addr == i_peer_addr[i]) begin
                match_idx = IDX_W'(i);
            end
        end
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_op.is_tick      = is_tick;
        o_op.elapsed      = elapsed;
        o_op.sender_index = is_tick ? UNKNOWN_INDEX : match_idx;
        o_op.frame_ok     = !is_tick && (match_idx != UNKNOWN_INDEX)
                            && (msg_type == i_liveness_type)
                            && ({1'b0, frame_len} >= MIN_LEN);
    end

endmodule

/* rtl/plm_queue.sv */
// ----------------------------------------------------------------------------
// plm_queue
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module plm_queue
    import plm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

/* rtl/plm_back.sv */
// ----------------------------------------------------------------------------
// plm_back
// Applies queued operations to peer timers, pending bits and the heartbeat
// counter, and holds one result in the output register.
// ----------------------------------------------------------------------------
module plm_back
    import plm_pkg::*;
#(
    parameter int PEER_COUNT = PEER_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    input  t_op                   i_op,
    output logic                  o_op_ready,
    input  logic [TIMER_W-1:0]    i_timeout_reload,
    input  logic [TIMER_W-1:0]    i_heartbeat_period,
    input  logic [SELF_W-1:0]     i_self_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [TIMER_W-1:0]    r_timer [PEER_COUNT];
    logic [TIMER_W-1:0]    n_timer [PEER_COUNT];
    logic [PEER_COUNT-1:0] r_pending, n_pending;
    logic [HB_W-1:0]       r_hb, n_hb;
    logic [HB_W-1:0]       hb_sum;
    logic                  r_out_valid;
    t_res                  r_res, n_res;
    logic                  do_pop;

    assign o_op_ready = !r_out_valid || i_ready;
    assign do_pop     = i_op_valid && o_op_ready;
    assign hb_sum     = r_hb + HB_W'(i_op.elapsed);

    always_comb begin
        n_timer   = r_timer;
        n_pending = r_pending;
        n_hb      = r_hb;
        n_res     = '0;
        if (i_op.is_tick) begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                if (r_pending[i] || (i_self_index == SELF_W'(i))) begin
                    n_timer[i] = i_timeout_reload;
                end else if (r_timer[i] > i_op.elapsed) begin
                    n_timer[i] = r_timer[i] - i_op.elapsed;
                end else begin
                    n_timer[i] = '0;
                end
            end
            n_pending = '0;
            if (hb_sum > HB_W'(i_heartbeat_period)) begin
                n_hb                 = '0;
                n_res.send_heartbeat = 1'b1;
            end else begin
                n_hb = hb_sum;
            end
        end else begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                if (i_op.frame_ok && (i_op.sender_index == IDX_W'(i))) begin
                    n_pending[i] = 1'b1;
                end
            end
        end
        for (int i = 0; i < PEER_COUNT; i++) begin
            n_res.alive_mask[i] = (n_timer[i] != '0) && (i_self_index != SELF_W'(i));
        end
        n_res.sender_index   = i_op.sender_index;
        n_res.frame_accepted = i_op.frame_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                r_timer[i] <= '0;
            end
            r_pending   <= '0;
            r_hb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_pop) begin
                r_timer     <= n_timer;
                r_pending   <= n_pending;
                r_hb        <= n_hb;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = OUT_DATA_W'(r_res);

endmodule

/* rtl/peer_liveness_monitor_core.sv */
// ----------------------------------------------------------------------------
// peer_liveness_monitor_core
// Heartbeat timeout monitor for a fixed set of peers.
//
// Input stream: tuser selects a time tick (0) or a frame header (1); tdata
// carries elapsed time, sender address, message type and frame length.
// Output stream: one result transfer per input transfer, in order, with the
// alive mask, heartbeat request, matched sender index and frame verdict.
// Configuration: write enable, register index and data; takes effect on
// the clock edge of the write.
// Path: each input passes through the two-entry queue into the back, whose
// result is registered in the output register. One item per cycle is
// sustained while the output accepts results; the front matches addresses
// combinationally and the back updates all timers together from the queue.
// Reset: timers, pending bits and the heartbeat counter clear, the queue
// empties and registers return to their defaults.
// Stall: the output register holds a result and the queue absorbs operations;
// input tready drops once the queue is full.
// ----------------------------------------------------------------------------
module peer_liveness_monitor_core
    import plm_pkg::*;
#(
    parameter int PEER_COUNT             = PEER_COUNT_DEF,
    parameter int LIVENESS_PAYLOAD_BYTES = LIVENESS_PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // elapsed[15:0], sender_addr[63:16], msg_type[71:64], frame_len[79:72]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // alive_mask[3:0], send_heartbeat[4], sender_index[7:5],
    // frame_accepted[8], zero[15:9]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [ADDR_W-1:0]  r_peer_addr [PEER_COUNT];
    logic [TIMER_W-1:0] r_timeout_reload;
    logic [TIMER_W-1:0] r_heartbeat_period;
    logic [SELF_W-1:0]  r_self_index;
    logic [TYPE_W-1:0]  r_liveness_type;

    logic push, queue_full, queue_valid, queue_pop;
    t_op  push_op, queue_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                r_peer_addr[i] <= '0;
            end
            r_timeout_reload   <= TIMEOUT_RELOAD_RST;
            r_heartbeat_period <= HEARTBEAT_PERIOD_RST;
            r_self_index       <= SELF_INDEX_RST;
            r_liveness_type    <= LIVENESS_TYPE_RST;
        end else if (i_cfg_we) begin
            for (int i = 0; i < PEER_COUNT; i++) begin
                if (i_cfg_idx == CFG_PEER_ADDR_0 + CFG_IDX_W'(i)) begin
                    r_peer_addr[i] <= i_cfg_data[ADDR_W-1:0];
                end
            end
            unique case (i_cfg_idx)
                CFG_TIMEOUT_RELOAD:   r_timeout_reload   <= i_cfg_data[TIMER_W-1:0];
                CFG_HEARTBEAT_PERIOD: r_heartbeat_period <= i_cfg_data[TIMER_W-1:0];
                CFG_SELF_INDEX:       r_self_index       <= i_cfg_data[SELF_W-1:0];
                CFG_LIVENESS_TYPE:    r_liveness_type    <= i_cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    plm_front #(
        .PEER_COUNT             (PEER_COUNT),
        .LIVENESS_PAYLOAD_BYTES (LIVENESS_PAYLOAD_BYTES)
    ) u_front (
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data          (s_axis_tdata),
        .i_user          (s_axis_tuser),
        .i_peer_addr     (r_peer_addr),
        .i_liveness_type (r_liveness_type),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_op            (push_op)
    );

    plm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_op    (queue_op)
    );

    plm_back #(
        .PEER_COUNT (PEER_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op_valid         (queue_valid),
        .i_op               (queue_op),
        .o_op_ready         (queue_pop),
        .i_timeout_reload   (r_timeout_reload),
        .i_heartbeat_period (r_heartbeat_period),
        .i_self_index       (r_self_index),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_data             (m_axis_tdata)
    );

endmodule

/* bench/tb_peer_liveness_monitor_core.sv */
// ----------------------------------------------------------------------------
// tb_peer_liveness_monitor_core
// Self-checking bench for the peer liveness monitor. A queue-fed driver
// offers tick and frame-header transfers with random gaps. A monitor
// predicts every result from its own model of the peer timers, the pending
// heard bits and the heartbeat counter, and compares each output transfer
// field by field. Directed items cover the register extremes, address
// matching, duplicate addresses, short and foreign frames and heartbeat
// wrap. Random phases reprogram all registers between runs. One long
// receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_peer_liveness_monitor_core;
    import plm_pkg::*;

    localparam int PEERS          = PEER_COUNT_DEF;
    localparam int MIN_LIVE_LEN   = 1 + LIVENESS_PAYLOAD_BYTES_DEF;
    localparam int IDLE_PCT       = 22;
    localparam int RAND_PHASES    = 4;
    localparam int PHASE_ITEMS    = 160;
    localparam int HOLD_AT_ITEM   = 300;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic               cmd;
        logic [TIMER_W-1:0] elapsed;
        logic [ADDR_W-1:0]  addr;
        logic [TYPE_W-1:0]  mtype;
        logic [LEN_W-1:0]   flen;
    } plm_item_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    peer_liveness_monitor_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // elapsed[15:0], sender_addr[63:16], msg_type[71:64], frame_len[79:72]
        .s_axis_tdata  (s_axis_tdata),
        // command[0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // alive_mask[3:0], send_heartbeat[4], sender_index[7:5],
        // frame_accepted[8], zero[15:9]
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    plm_item_t pending_items[$];
    t_res      expected_results[$];
    plm_item_t drv_item;
    logic      in_fire   = 1'b0;
    logic      no_idle   = 1'b0;
    int        n_in      = 0;
    int        n_tick    = 0;
    int        n_frame   = 0;
    int        n_acc     = 0;
    int        n_hb      = 0;
    int        n_cfg     = 0;
    int        n_err     = 0;
    int        quiet     = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    // register values as programmed by the stimulus
    logic [ADDR_W-1:0]  st_addr[PEERS];
    logic [TIMER_W-1:0] st_reload = TIMEOUT_RELOAD_RST;
    logic [TIMER_W-1:0] st_period = HEARTBEAT_PERIOD_RST;
    logic [SELF_W-1:0]  st_self   = SELF_INDEX_RST;
    logic [TYPE_W-1:0]  st_type   = LIVENESS_TYPE_RST;

    // predictor state and its view of the registers
    logic [ADDR_W-1:0]  m_addr[PEERS];
    logic [TIMER_W-1:0] m_reload = TIMEOUT_RELOAD_RST;
    logic [TIMER_W-1:0] m_period = HEARTBEAT_PERIOD_RST;
    logic [SELF_W-1:0]  m_self   = SELF_INDEX_RST;
    logic [TYPE_W-1:0]  m_type   = LIVENESS_TYPE_RST;
    logic [TIMER_W-1:0] tmr[PEERS];
    logic [PEERS-1:0]   pend = '0;
    logic [HB_W-1:0]    hb   = '0;

    initial begin
        for (int i = 0; i < PEERS; i++) begin
            st_addr[i] = '0;
            m_addr[i]  = '0;
            tmr[i]     = '0;
        end
    end

    function automatic t_res liveness_update(input plm_item_t it);
        t_res r;
        r.alive_mask     = '0;
        r.send_heartbeat = 1'b0;
        r.sender_index   = UNKNOWN_INDEX;
        r.frame_accepted = 1'b0;
        if (it.cmd == CMD_TICK) begin
            for (int i = 0; i < PEERS; i++) begin
                if (pend[i]) begin
                    tmr[i] = m_reload;
                end else begin
                    tmr[i] = (tmr[i] > it.elapsed) ? tmr[i] - it.elapsed : '0;
                end
            end
            pend = '0;
            if (m_self < PEERS) begin
                tmr[m_self] = m_reload;
            end
            hb = hb + it.elapsed;
            if (hb > {1'b0, m_period}) begin
                hb = '0;
                r.send_heartbeat = 1'b1;
            end
        end else begin
            // scan downward so the lowest matching peer wins
            for (int i = PEERS - 1; i >= 0; i--) begin
                if (m_addr[i] == it.addr) begin
                    r.sender_index = IDX_W'(i);
                end
            end
            if (r.sender_index != UNKNOWN_INDEX && it.mtype == m_type &&
                it.flen >= MIN_LIVE_LEN) begin
                pend[r.sender_index[SELF_W-1:0]] = 1'b1;
                r.frame_accepted = 1'b1;
            end
        end
        for (int i = 0; i < PEERS; i++) begin
            r.alive_mask[i] = (tmr[i] != '0) && (i != m_self);
        end
        return r;
    endfunction

    function automatic plm_item_t mk_tick(input logic [TIMER_W-1:0] el);
        plm_item_t it;
        it.cmd     = CMD_TICK;
        it.elapsed = el;
        it.addr    = ADDR_W'({$urandom(), $urandom()});
        it.mtype   = TYPE_W'($urandom());
        it.flen    = LEN_W'($urandom_range(0, 250));
        return it;
    endfunction

    function automatic plm_item_t mk_frame(input logic [ADDR_W-1:0] a,
                                           input logic [TYPE_W-1:0] t,
                                           input logic [LEN_W-1:0]  l);
        plm_item_t it;
        it.cmd     = CMD_FRAME;
        it.elapsed = TIMER_W'($urandom());
        it.addr    = a;
        it.mtype   = t;
        it.flen    = l;
        return it;
    endfunction

    // mostly frames from configured peers with the liveness type and a valid length
    function automatic plm_item_t rand_item();
        plm_item_t it;
        logic [ADDR_W-1:0]  a;
        logic [TYPE_W-1:0]  t;
        logic [LEN_W-1:0]   l;
        logic [TIMER_W-1:0] el;
        a  = ($urandom_range(0, 99) < 85) ? st_addr[$urandom_range(0, PEERS - 1)]
                                          : ADDR_W'({$urandom(), $urandom()});
        t  = ($urandom_range(0, 99) < 80) ? st_type : TYPE_W'($urandom());
        l  = ($urandom_range(0, 99) < 80) ? LEN_W'($urandom_range(MIN_LIVE_LEN, 250))
                                          : LEN_W'($urandom_range(0, MIN_LIVE_LEN - 1));
        el = ($urandom_range(0, 7) == 0) ? TIMER_W'($urandom())
                                         : TIMER_W'($urandom_range(0, st_reload / 3 + 1));
        if ($urandom_range(0, 99) < 40) begin
            it = mk_tick(el);
        end else begin
            it = mk_frame(a, t, l);
        end
        return it;
    endfunction

    task automatic rand_regs();
        for (int i = 0; i < PEERS; i++) begin
            st_addr[i] = ADDR_W'({$urandom(), $urandom()});
        end
        if ($urandom_range(0, 3) == 0) begin
            st_addr[PEERS - 1] = st_addr[$urandom_range(0, PEERS - 2)];
        end
        st_reload = TIMER_W'($urandom_range(1, 4000));
        st_period = TIMER_W'($urandom_range(0, 3000));
        st_self   = SELF_W'($urandom_range(0, 3));
        st_type   = TYPE_W'($urandom());
    endtask

    // call at a falling edge with the block idle
    task automatic write_regs();
        logic [CFG_IDX_W-1:0] r;
        for (int k = 0; k < 8; k++) begin
            r = CFG_IDX_W'(k);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= r;
            case (r)
                CFG_TIMEOUT_RELOAD:   i_cfg_data <= CFG_DATA_W'(st_reload);
                CFG_HEARTBEAT_PERIOD: i_cfg_data <= CFG_DATA_W'(st_period);
                CFG_SELF_INDEX:       i_cfg_data <= CFG_DATA_W'(st_self);
                CFG_LIVENESS_TYPE:    i_cfg_data <= CFG_DATA_W'(st_type);
                default:              i_cfg_data <= st_addr[r - CFG_PEER_ADDR_0];
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    task automatic wait_drain();
        do begin
            @(posedge i_clk);
        end while (pending_items.size() != 0 || s_axis_tvalid ||
                   expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // driver: hold the offered transfer until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (pending_items.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drv_item = pending_items.pop_front();
                s_axis_tuser  <= drv_item.cmd;
                s_axis_tdata  <= {drv_item.flen, drv_item.mtype, drv_item.addr,
                                  drv_item.elapsed};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (!hold_done && n_in >= HOLD_AT_ITEM) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin : monitor
        plm_item_t seen;
        t_res      got;
        t_res      want;
        logic      out_fire;
        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire  = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT_RELOAD:   m_reload = i_cfg_data[TIMER_W-1:0];
                CFG_HEARTBEAT_PERIOD: m_period = i_cfg_data[TIMER_W-1:0];
                CFG_SELF_INDEX:       m_self   = i_cfg_data[SELF_W-1:0];
                CFG_LIVENESS_TYPE:    m_type   = i_cfg_data[TYPE_W-1:0];
                default:              m_addr[i_cfg_idx - CFG_PEER_ADDR_0] =
                                          i_cfg_data[ADDR_W-1:0];
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.cmd     = s_axis_tuser;
            seen.elapsed = s_axis_tdata[15:0];
            seen.addr    = s_axis_tdata[63:16];
            seen.mtype   = s_axis_tdata[71:64];
            seen.flen    = s_axis_tdata[79:72];
            want = liveness_update(seen);
            expected_results.push_back(want);
            n_in++;
            if (seen.cmd == CMD_TICK) begin
                n_tick++;
            end else begin
                n_frame++;
            end
            n_acc += want.frame_accepted;
            n_hb  += want.send_heartbeat;
        end
        if (out_fire) begin
            got = t_res'(m_axis_tdata[$bits(t_res)-1:0]);
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                n_err++;
            end else begin
                want = expected_results.pop_front();
                if (got.alive_mask != want.alive_mask) begin
                    $error("alive_mask: expected %h, got %h", want.alive_mask, got.alive_mask);
                    n_err++;
                end
                if (got.send_heartbeat != want.send_heartbeat) begin
                    $error("send_heartbeat: expected %0d, got %0d",
                           want.send_heartbeat, got.send_heartbeat);
                    n_err++;
                end
                if (got.sender_index != want.sender_index) begin
                    $error("sender_index: expected %0d, got %0d",
                           want.sender_index, got.sender_index);
                    n_err++;
                end
                if (got.frame_accepted != want.frame_accepted) begin
                    $error("frame_accepted: expected %0d, got %0d",
                           want.frame_accepted, got.frame_accepted);
                    n_err++;
                end
            end
        end
        if ((i_rst_n && s_axis_tvalid && s_axis_tready) || out_fire) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: every peer address is zero, peer 0 is self
        pending_items.push_back(mk_frame('0, LIVENESS_TYPE_RST, LEN_W'(MIN_LIVE_LEN)));
        pending_items.push_back(mk_frame('0, LIVENESS_TYPE_RST, LEN_W'(MIN_LIVE_LEN - 1)));
        pending_items.push_back(mk_frame(ADDR_W'(1), LIVENESS_TYPE_RST, 8'd250));
        pending_items.push_back(mk_tick('0));
        pending_items.push_back(mk_tick('1));
        wait_drain();

        // all-ones and zero addresses, duplicate peer address, widest reload
        st_addr[0] = '1;
        st_addr[1] = '0;
        st_addr[2] = ADDR_W'({$urandom(), $urandom()});
        st_addr[3] = st_addr[2];
        st_reload  = '1;
        st_period  = '0;
        st_self    = 2'd3;
        st_type    = '1;
        write_regs();
        pending_items.push_back(mk_frame(st_addr[1], st_type, LEN_W'(MIN_LIVE_LEN)));
        pending_items.push_back(mk_frame(st_addr[1], st_type, 8'd250));
        pending_items.push_back(mk_frame(st_addr[3], st_type, LEN_W'(MIN_LIVE_LEN)));
        pending_items.push_back(mk_frame(st_addr[0], st_type - 8'd1, 8'd250));
        pending_items.push_back(mk_frame(st_addr[0], st_type, LEN_W'(MIN_LIVE_LEN - 1)));
        pending_items.push_back(mk_tick(16'd1));
        pending_items.push_back(mk_tick('0));
        pending_items.push_back(mk_frame(ADDR_W'(48'h5555_AAAA_0F0F), st_type, 8'd100));
        pending_items.push_back(mk_tick('1));
        wait_drain();

        // zero reload, widest period, liveness type zero
        for (int i = 0; i < PEERS; i++) begin
            st_addr[i] = ADDR_W'({$urandom(), $urandom()}) ^ ADDR_W'(i);
        end
        st_reload = '0;
        st_period = '1;
        st_self   = 2'd1;
        st_type   = '0;
        write_regs();
        pending_items.push_back(mk_frame(st_addr[2], st_type, LEN_W'(MIN_LIVE_LEN)));
        pending_items.push_back(mk_tick('1));
        pending_items.push_back(mk_tick(16'd1));
        pending_items.push_back(mk_frame(st_addr[3], st_type, 8'd0));
        pending_items.push_back(mk_frame(st_addr[1], st_type, 8'd200));
        pending_items.push_back(mk_tick('0));
        wait_drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            rand_regs();
            write_regs();
            no_idle = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pending_items.push_back(rand_item());
            end
            wait_drain();
        end
        no_idle = 1'b0;

        $display("Ran %0d ticks and %0d frame headers over %0d register settings.",
                 n_tick, n_frame, n_cfg);
        $display("%0d frames marked peers heard, %0d heartbeat requests, %0d mismatches.",
                 n_acc, n_hb, n_err);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
